### src/bmp_pixel_decoder_top_defines.svh
// Assertion macros for the BMP pixel decoder top level.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BMP_PIXEL_DECODER_TOP_DEFINES_SVH
`define BMP_PIXEL_DECODER_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define BMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define BMP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/bmp_pkg.sv
// Shared types, codes and helpers of the BMP pixel decoder.
// No dependencies; imported by all modules but bmp_ram.
package bmp_pkg;

  localparam int unsigned MAX_WIDTH_DEF     = 4096;
  localparam int unsigned MAX_HEIGHT_DEF    = 4096;
  localparam int unsigned PALETTE_DEPTH_DEF = 256;

  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_DATA    = 1'b1;

  localparam logic [2:0] MODE_1BPP  = 3'd0;
  localparam logic [2:0] MODE_2BPP  = 3'd1;
  localparam logic [2:0] MODE_4BPP  = 3'd2;
  localparam logic [2:0] MODE_8BPP  = 3'd3;
  localparam logic [2:0] MODE_24BPP = 3'd4;
  localparam logic [2:0] MODE_32BPP = 3'd5;

  localparam logic [1:0] CFG_PIXEL_MODE   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic        op;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
    logic [7:0]  data_byte;
  } bmp_in_t;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_of_byte;
    logic        image_done;
  } bmp_out_t;

  // Pixel request from the unpacker to the color stage.
  typedef struct packed {
    logic        indexed;
    logic        idx_ok;
    logic [23:0] color;
    logic [7:0]  alpha;
    logic [11:0] column;
    logic [11:0] row;
    logic        last;
    logic        done;
  } bmp_req_t;

  typedef struct packed {
    logic busy;
    logic frame_over;
  } bmp_status_t;

  // Unused modes decode as 8-bit indexed.
  function automatic logic [5:0] mode_bpp(input logic [2:0] mode);
    case (mode)
      MODE_1BPP:  return 6'd1;
      MODE_2BPP:  return 6'd2;
      MODE_4BPP:  return 6'd4;
      MODE_24BPP: return 6'd24;
      MODE_32BPP: return 6'd32;
      default:    return 6'd8;
    endcase
  endfunction

endpackage

### src/bmp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bmp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data when no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/bmp_unpack.sv
// Byte slot and frame counters: unpacks one byte into pixel requests, one
// per cycle if not stalled; drives palette RAM ports. Depends on bmp_pkg.
module bmp_unpack #(
  parameter int unsigned MAX_WIDTH     = bmp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT    = bmp_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned PALETTE_DEPTH = bmp_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               restart_i,
  input  logic [2:0]                         mode_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    height_i,
  input  logic [$clog2(MAX_WIDTH*4+1)-1:0]   dbytes_i,
  input  logic [$clog2(MAX_WIDTH*4+1)-1:0]   pitch_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bmp_pkg::bmp_in_t                   in_i,
  output logic                               ram_we_o,
  output logic [$clog2(PALETTE_DEPTH)-1:0]   ram_waddr_o,
  output logic [23:0]                        ram_wdata_o,
  output logic                               ram_re_o,
  output logic [$clog2(PALETTE_DEPTH)-1:0]   ram_raddr_o,
  output logic                               req_valid_o,
  output bmp_pkg::bmp_req_t                  req_o,
  input  logic                               req_ready_i,
  output bmp_pkg::bmp_status_t               status_o
);
  import bmp_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH+1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT+1);
  localparam int unsigned BW = $clog2(MAX_WIDTH*4+1);
  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  logic          slot_valid_q, slot_valid_d;
  bmp_in_t       slot_q, slot_d;
  logic [7:0]    sh_q, sh_d;
  logic [2:0]    k_q, k_d;
  logic [WW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic [BW-1:0] bir_q, bir_d;
  logic [23:0]   asm_q, asm_d;
  logic [1:0]    phase_q, phase_d;

  logic [5:0]    bpp;
  logic          indexed;
  logic [7:0]    idx;
  logic [7:0]    sh_next;
  logic [2:0]    last_k;
  logic [1:0]    last_phase;
  logic [7:0]    b;
  logic          is_data, frame_over, in_region, col_ok, col_last, row_last;
  logic          live, emit, finish, adv, consume, accept;
  logic [23:0]   asm_new;
  logic [BW-1:0] bir_inc;
  logic [HW-1:0] row_out;

  assign bpp        = mode_bpp(mode_i);
  assign indexed    = (bpp <= 6'd8);
  assign last_phase = (bpp == 6'd24) ? 2'd2 : 2'd3;
  assign b          = slot_q.data_byte;

  always_comb begin
    case (bpp)
      6'd1: begin
        idx     = {7'd0, sh_q[7]};
        sh_next = {sh_q[6:0], 1'b0};
        last_k  = 3'd7;
      end
      6'd2: begin
        idx     = {6'd0, sh_q[7:6]};
        sh_next = {sh_q[5:0], 2'd0};
        last_k  = 3'd3;
      end
      6'd4: begin
        idx     = {4'd0, sh_q[7:4]};
        sh_next = {sh_q[3:0], 4'd0};
        last_k  = 3'd1;
      end
      default: begin
        idx     = sh_q;
        sh_next = 8'd0;
        last_k  = 3'd0;
      end
    endcase
  end

  always_comb begin
    case (phase_q)
      2'd0:    asm_new = asm_q | {16'd0, b};
      2'd1:    asm_new = asm_q | {8'd0, b, 8'd0};
      2'd2:    asm_new = asm_q | {b, 16'd0};
      default: asm_new = asm_q;
    endcase
  end

  assign is_data    = (slot_q.op == OP_DATA);
  assign frame_over = (row_q >= height_i);
  assign in_region  = (bir_q < dbytes_i);
  assign col_ok     = (col_q < width_i);
  assign col_last   = (({1'b0, col_q} + 1'b1) == {1'b0, width_i});
  assign row_last   = (({1'b0, row_q} + 1'b1) == {1'b0, height_i});
  assign row_out    = height_i - row_q - 1'b1;

  // pad bytes and bytes past the frame go through the slot and give nothing
  assign live    = slot_valid_q && is_data && !frame_over && in_region;
  assign emit    = live && col_ok && (indexed || (phase_q >= last_phase));
  assign finish  = !(emit && indexed) || (k_q == last_k) || col_last;
  assign adv     = slot_valid_q && (!emit || req_ready_i);
  assign consume = adv && finish;

  assign in_stall_o = slot_valid_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;

  assign ram_we_o    = slot_valid_q && !is_data &&
                       (32'(slot_q.palette_index) < PALETTE_DEPTH);
  assign ram_waddr_o = slot_q.palette_index[AW-1:0];
  assign ram_wdata_o = slot_q.palette_color;
  assign ram_re_o    = emit && indexed && req_ready_i;
  assign ram_raddr_o = idx[AW-1:0];

  assign req_valid_o    = emit;
  assign req_o.indexed  = indexed;
  assign req_o.idx_ok   = (32'(idx) < PALETTE_DEPTH);
  assign req_o.color    = indexed ? 24'd0 : asm_new;
  assign req_o.alpha    = (bpp == 6'd32) ? b : 8'd0;
  assign req_o.column   = 12'(col_q);
  assign req_o.row      = 12'(row_out);
  assign req_o.last     = finish;
  assign req_o.done     = col_last && row_last;

  assign status_o.busy       = slot_valid_q;
  assign status_o.frame_over = frame_over;

  always_comb begin
    slot_valid_d = slot_valid_q;
    slot_d       = slot_q;
    sh_d         = sh_q;
    k_d          = k_q;
    col_d        = col_q;
    row_d        = row_q;
    bir_d        = bir_q;
    asm_d        = asm_q;
    phase_d      = phase_q;
    bir_inc      = bir_q + 1'b1;

    if (adv && emit) begin
      col_d = col_q + 1'b1;
      sh_d  = sh_next;
      k_d   = k_q + 1'b1;
    end

    if (adv && live && !indexed) begin
      if (phase_q >= last_phase) begin
        asm_d   = 24'd0;
        phase_d = 2'd0;
      end else begin
        asm_d   = asm_new;
        phase_d = phase_q + 1'b1;
      end
    end

    // end of byte: advance the row position, wrap at the pitch
    if (consume && is_data && !frame_over) begin
      if (bir_inc >= pitch_i) begin
        bir_d   = '0;
        col_d   = '0;
        asm_d   = 24'd0;
        phase_d = 2'd0;
        row_d   = row_q + 1'b1;
      end else begin
        bir_d = bir_inc;
      end
    end

    if (consume) begin
      slot_valid_d = 1'b0;
    end
    if (accept) begin
      slot_valid_d = 1'b1;
      slot_d       = in_i;
      sh_d         = in_i.data_byte;
      k_d          = 3'd0;
    end

    if (restart_i) begin
      col_d   = '0;
      row_d   = '0;
      bir_d   = '0;
      asm_d   = 24'd0;
      phase_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
      k_q          <= 3'd0;
      col_q        <= '0;
      row_q        <= '0;
      bir_q        <= '0;
      asm_q        <= 24'd0;
      phase_q      <= 2'd0;
    end else begin
      slot_valid_q <= slot_valid_d;
      k_q          <= k_d;
      col_q        <= col_d;
      row_q        <= row_d;
      bir_q        <= bir_d;
      asm_q        <= asm_d;
      phase_q      <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    sh_q   <= sh_d;
  end

endmodule

### src/bmp_pixout.sv
// Color stage and output register: pairs each request with its palette
// read data and presents the pixel transaction. Depends on bmp_pkg.
module bmp_pixout (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  bmp_pkg::bmp_req_t req_i,
  output logic              req_ready_o,
  input  logic [23:0]       ram_rdata_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bmp_pkg::bmp_out_t out_o
);
  import bmp_pkg::*;

  logic     s2_valid_q;
  bmp_req_t s2_q;
  logic     out_valid_q;
  bmp_out_t out_q;
  bmp_out_t pix;
  logic     out_ready, s2_load, s2_move;
  logic [23:0] color;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign req_ready_o = !s2_valid_q || out_ready;
  assign s2_load     = req_valid_i && req_ready_o;
  assign s2_move     = s2_valid_q && out_ready;

  // read data stays put while the stage waits: no read is issued then
  assign color = s2_q.indexed ? (s2_q.idx_ok ? ram_rdata_i : 24'd0) : s2_q.color;

  assign pix.blue         = color[7:0];
  assign pix.green        = color[15:8];
  assign pix.red          = color[23:16];
  assign pix.alpha        = s2_q.alpha;
  assign pix.column       = s2_q.column;
  assign pix.row          = s2_q.row;
  assign pix.last_of_byte = s2_q.last;
  assign pix.image_done   = s2_q.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_load || (s2_valid_q && !out_ready);
      out_valid_q <= s2_move || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_q <= req_i;
    end
    if (s2_move) begin
      out_q <= pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### src/bmp_pixel_decoder_top.sv
// A byte's first pixel passes the unpacker slot, color stage and output
// register. One input byte per cycle in 8, 24 and 32-bit modes unless
// back-pressure holds a pixel byte, and for pad bytes and palette writes;
// 1, 2 and 4-bit bytes give pixels (up to 8) one at a time: one read port.
// Reset: 8-bit indexed, 1x1 image, counters zero; the palette is not cleared.
`include "bmp_pixel_decoder_top_defines.svh"

module bmp_pixel_decoder_top #(
  parameter int unsigned MAX_WIDTH     = bmp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT    = bmp_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned PALETTE_DEPTH = bmp_pkg::PALETTE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [12:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bmp_pkg::bmp_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bmp_pkg::bmp_out_t out_o
);
  import bmp_pkg::*;

  localparam int unsigned WW   = $clog2(MAX_WIDTH+1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT+1);
  localparam int unsigned BW   = $clog2(MAX_WIDTH*4+1);
  localparam int unsigned AW   = $clog2(PALETTE_DEPTH);
  localparam int unsigned BITW = WW + 6;

  logic [2:0]      mode_q, mode_d;
  logic [WW-1:0]   w_q, w_d;
  logic [HW-1:0]   h_q, h_d;
  logic [BW-1:0]   dbytes_q, dbytes_d;
  logic [BW-1:0]   pitch_q, pitch_d;
  logic [BITW-1:0] bits;
  logic            cfg_hit;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [23:0]       ram_wdata, ram_rdata;
  logic              req_valid, req_ready;
  bmp_req_t          req;
  bmp_status_t       status;

  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i inside {CFG_PIXEL_MODE, CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT});

  // zero counts as one, oversize saturates
  always_comb begin
    mode_d = mode_q;
    w_d    = w_q;
    h_d    = h_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PIXEL_MODE: mode_d = cfg_data_i[2:0];
        CFG_IMAGE_WIDTH: begin
          if (cfg_data_i == 13'd0) begin
            w_d = WW'(1);
          end else if (32'(cfg_data_i) > MAX_WIDTH) begin
            w_d = WW'(MAX_WIDTH);
          end else begin
            w_d = WW'(cfg_data_i);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          if (cfg_data_i == 13'd0) begin
            h_d = HW'(1);
          end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
            h_d = HW'(MAX_HEIGHT);
          end else begin
            h_d = HW'(cfg_data_i);
          end
        end
        default: ;
      endcase
    end
  end

  assign bits     = BITW'(w_d) * BITW'(mode_bpp(mode_d));
  assign dbytes_d = BW'((bits + BITW'(7)) >> 3);
  assign pitch_d  = BW'(((bits + BITW'(31)) >> 5) << 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_8BPP;
      w_q      <= WW'(1);
      h_q      <= HW'(1);
      dbytes_q <= BW'(1);
      pitch_q  <= BW'(4);
    end else if (cfg_hit) begin
      mode_q   <= mode_d;
      w_q      <= w_d;
      h_q      <= h_d;
      dbytes_q <= dbytes_d;
      pitch_q  <= pitch_d;
    end
  end

  bmp_unpack #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_unpack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg_hit),
    .mode_i     (mode_q),
    .width_i    (w_q),
    .height_i   (h_q),
    .dbytes_i   (dbytes_q),
    .pitch_i    (pitch_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .req_valid_o(req_valid),
    .req_o      (req),
    .req_ready_i(req_ready),
    .status_o   (status)
  );

  bmp_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bmp_pixout u_pixout (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_i      (req),
    .req_ready_o(req_ready),
    .ram_rdata_i(ram_rdata),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  `BMP_ASSERT_NEVER(a_ram_rw_same, ram_we && ram_re, "palette write and lookup collide")
  `BMP_ASSERT(a_done_last, out_valid_o && out_o.image_done |-> out_o.last_of_byte, "done without last")
  `BMP_ASSERT(a_accept_busy, in_valid_i && !in_stall_o |=> status.busy, "accepted byte lost")
  `BMP_ASSERT(a_cfg_restart, cfg_hit |=> !status.frame_over, "config write did not restart frame")

endmodule

### verif/tb_top.sv
// Self-checking testbench of bmp_pixel_decoder_top: palette writes and pixel bytes go in,
// decoded pixels are compared with an in-bench decoder of the same pixel array.
// Depends on bmp_pkg for the payload structs, the operation, mode and register codes.
module tb_top;
  import bmp_pkg::*;

  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_PIXEL_MODE;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  bmp_in_t     in_d = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  bmp_out_t    out_px;

  bmp_pixel_decoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_d),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_px)
  );

  always #2 clk_i = ~clk_i;

  bmp_in_t  byte_q [$];
  bmp_out_t pixel_q [$];
  int       fail_count = 0;
  bit       calm = 1'b0;

  // Decoder copy: configuration, palette and frame cursor.
  logic [2:0]  mode_r = MODE_8BPP;
  logic [12:0] width_r = 13'd1;
  logic [12:0] height_r = 13'd1;
  logic [23:0] pal [256];
  logic [12:0] col_cnt = '0;
  logic [12:0] row_cnt = '0;
  logic [14:0] byte_pos = '0;
  logic [23:0] assembly = '0;
  logic [1:0]  phase = '0;

  // Stimulus side: palette entries already written and a light frame cursor.
  bit          pal_written [256];
  logic [7:0]  written_idx [$];
  logic [2:0]  g_mode = MODE_8BPP;
  logic [12:0] g_width = 13'd1;
  logic [12:0] g_height = 13'd1;
  int          g_row = 0;
  int          g_pos = 0;

  function automatic int eff_dim(input logic [12:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int bits_of_mode(input logic [2:0] m);
    case (m)
      MODE_1BPP:  return 1;
      MODE_2BPP:  return 2;
      MODE_4BPP:  return 4;
      MODE_24BPP: return 24;
      MODE_32BPP: return 32;
      default:    return 8;
    endcase
  endfunction

  function automatic int draw_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bmp_out_t make_pixel(input logic [23:0] color, input logic [7:0] alpha,
                                          input int w, input int h);
    bmp_out_t px;
    px.blue = color[7:0];
    px.green = color[15:8];
    px.red = color[23:16];
    px.alpha = alpha;
    px.column = col_cnt[11:0];
    px.row = 12'(h - 1 - int'(row_cnt));
    px.last_of_byte = 1'b0;
    px.image_done = (int'(col_cnt) + 1 == w && int'(row_cnt) + 1 == h);
    return px;
  endfunction

  function automatic void apply_cfg(input logic [1:0] idx, input logic [12:0] val);
    case (idx)
      CFG_PIXEL_MODE:   mode_r = val[2:0];
      CFG_IMAGE_WIDTH:  width_r = val;
      CFG_IMAGE_HEIGHT: height_r = val;
      default:          return;
    endcase
    col_cnt = '0;
    row_cnt = '0;
    byte_pos = '0;
    assembly = '0;
    phase = '0;
  endfunction

  // Expected pixels of one accepted transaction.
  function automatic void decode_byte(input bmp_in_t item);
    bmp_out_t   px [8];
    int         n, w, h, bpp, data_bytes, pitch, per;
    logic [7:0] idx;
    logic [7:0] alpha;
    n = 0;
    if (item.op == OP_PALETTE) begin
      pal[item.palette_index] = item.palette_color;
      return;
    end
    w = eff_dim(width_r, MAX_WIDTH_DEF);
    h = eff_dim(height_r, MAX_HEIGHT_DEF);
    if (int'(row_cnt) >= h) return;
    bpp = bits_of_mode(mode_r);
    data_bytes = (w * bpp + 7) / 8;
    pitch = ((w * bpp + 31) / 32) * 4;
    if (int'(byte_pos) < data_bytes) begin
      if (bpp <= 8) begin
        per = 8 / bpp;
        for (int k = 0; k < per && int'(col_cnt) < w; k++) begin
          idx = 8'((int'(item.data_byte) >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1));
          px[n] = make_pixel(pal[idx], 8'd0, w, h);
          n++;
          col_cnt++;
        end
      end else begin
        if (phase < 2'd3) assembly = assembly | (24'(item.data_byte) << (8 * phase));
        if (int'(phase) >= ((bpp == 24) ? 2 : 3)) begin
          alpha = (bpp == 32) ? item.data_byte : 8'd0;
          if (int'(col_cnt) < w) begin
            px[n] = make_pixel(assembly, alpha, w, h);
            n++;
            col_cnt++;
          end
          assembly = '0;
          phase = '0;
        end else begin
          phase++;
        end
      end
    end
    byte_pos++;
    if (int'(byte_pos) >= pitch) begin
      byte_pos = '0;
      col_cnt = '0;
      assembly = '0;
      phase = '0;
      row_cnt++;
    end
    if (n > 0) px[n-1].last_of_byte = 1'b1;
    for (int k = 0; k < n; k++) pixel_q.push_back(px[k]);
  endfunction

  function automatic void queue_palette(input logic [7:0] idx, input logic [23:0] color);
    bmp_in_t item;
    item.op = OP_PALETTE;
    item.palette_index = idx;
    item.palette_color = color;
    item.data_byte = 8'($urandom());
    byte_q.push_back(item);
    if (!pal_written[idx]) begin
      pal_written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
  endfunction

  // Queue one pixel byte; returns 1 when the byte still falls inside the frame.
  function automatic bit queue_data(input logic [7:0] raw);
    bmp_in_t item;
    int      w, h, bpp, pitch;
    bit      live;
    w = eff_dim(g_width, MAX_WIDTH_DEF);
    h = eff_dim(g_height, MAX_HEIGHT_DEF);
    bpp = bits_of_mode(g_mode);
    pitch = ((w * bpp + 31) / 32) * 4;
    live = (g_row < h);
    item.op = OP_DATA;
    item.palette_index = 8'($urandom());
    item.palette_color = 24'($urandom());
    item.data_byte = raw;
    // The low-depth modes only reach entries 0 to 15, which the opening fill writes;
    // in 8-bit mode steer a data byte away from entries never written.
    if (live && bpp == 8 && g_pos < w && !pal_written[raw])
      item.data_byte = written_idx[$urandom_range(0, written_idx.size() - 1)];
    if (live) begin
      g_pos++;
      if (g_pos >= pitch) begin
        g_pos = 0;
        g_row++;
      end
    end
    byte_q.push_back(item);
    return live;
  endfunction

  task automatic write_cfg(input logic [1:0] idx, input logic [12:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    apply_cfg(idx, val);
    case (idx)
      CFG_PIXEL_MODE:   g_mode = val[2:0];
      CFG_IMAGE_WIDTH:  g_width = val;
      default:          g_height = val;
    endcase
    g_row = 0;
    g_pos = 0;
  endtask

  task automatic set_frame(input logic [2:0] m, input logic [12:0] w, input logic [12:0] h);
    write_cfg(CFG_PIXEL_MODE, 13'(m));
    write_cfg(CFG_IMAGE_WIDTH, w);
    write_cfg(CFG_IMAGE_HEIGHT, h);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Hold until every byte is accepted and every pixel is out, then let the pipe empty.
  task automatic wait_idle();
    @(negedge clk_i);
    while (byte_q.size() != 0 || in_valid || pixel_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Driver: one transaction per accepted edge, random gaps between them.
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_d);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (byte_q.size() > 0) begin
          in_d <= byte_q.pop_front();
          in_valid <= 1'b1;
          gap_left <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= draw_gap();
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  bmp_out_t want_px;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel at column %0d row %0d", out_px.column, out_px.row);
        fail_count++;
      end else begin
        want_px = pixel_q.pop_front();
        check_field("blue", 32'(want_px.blue), 32'(out_px.blue));
        check_field("green", 32'(want_px.green), 32'(out_px.green));
        check_field("red", 32'(want_px.red), 32'(out_px.red));
        check_field("alpha", 32'(want_px.alpha), 32'(out_px.alpha));
        check_field("column", 32'(want_px.column), 32'(out_px.column));
        check_field("row", 32'(want_px.row), 32'(out_px.row));
        check_field("last_of_byte", 32'(want_px.last_of_byte), 32'(out_px.last_of_byte));
        check_field("image_done", 32'(want_px.image_done), 32'(out_px.image_done));
      end
    end
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int          random_items;
    int          nbytes, total, w, h;
    logic [2:0]  m;
    logic [12:0] wv, hv;
    random_items = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Palette fill with the color extremes, reset setting of 8-bit 1x1.
    queue_palette(8'd0, 24'h000000);
    queue_palette(8'd255, 24'hFFFFFF);
    for (int i = 1; i < 16; i++) queue_palette(8'(i), 24'($urandom()));
    void'(queue_data(8'hFF));
    void'(queue_data(8'h00));
    void'(queue_data(8'h5A));
    void'(queue_data(8'hA5));
    void'(queue_data(8'hFF));   // past the frame, dropped
    wait_idle();

    // Partial last byte in 1-bit mode.
    set_frame(MODE_1BPP, 13'd9, 13'd1);
    void'(queue_data(8'hA5));
    void'(queue_data(8'h80));
    void'(queue_data(8'h00));
    void'(queue_data(8'hFF));
    wait_idle();
    set_frame(MODE_24BPP, 13'd1, 13'd1);
    void'(queue_data(8'hFF));
    void'(queue_data(8'h00));
    void'(queue_data(8'h81));
    void'(queue_data(8'h7E));
    wait_idle();
    set_frame(MODE_32BPP, 13'd8191, 13'd1);
    for (int i = 0; i < 8; i++) void'(queue_data(8'($urandom())));
    wait_idle();
    // Spare mode decodes as 8-bit indexed; zero width counts as one.
    set_frame(MODE_SPARE_HI, 13'd0, 13'd8191);
    for (int i = 0; i < 6; i++) void'(queue_data(8'($urandom())));
    wait_idle();
    set_frame(MODE_4BPP, 13'd4096, 13'd4096);
    for (int i = 0; i < 3; i++) void'(queue_data(8'($urandom())));
    wait_idle();

    // Random frames top the directed transactions up to about 120 in all.
    while (random_items < 70) begin
      calm = ($urandom_range(0, 4) == 0);
      m = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 4))
          0:       wv = 13'd0;
          1:       wv = 13'd4096;
          2:       wv = 13'd8191;
          3:       wv = 13'd1;
          default: wv = 13'($urandom_range(1, 8191));
        endcase
        case ($urandom_range(0, 3))
          0:       hv = 13'd0;
          1:       hv = 13'd4096;
          2:       hv = 13'd8191;
          default: hv = 13'($urandom_range(1, 3));
        endcase
        nbytes = $urandom_range(8, 24);
      end else begin
        wv = 13'($urandom_range(1, 12));
        hv = 13'($urandom_range(1, 3));
        w = int'(wv);
        h = int'(hv);
        total = ((w * bits_of_mode(m) + 31) / 32) * 4 * h;
        nbytes = total + $urandom_range(0, 3);
        // Cut some frames short; the next setting restarts them.
        if ($urandom_range(0, 4) == 0) nbytes = $urandom_range(1, total);
      end
      set_frame(m, wv, hv);
      for (int i = 0; i < nbytes; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_palette(8'($urandom()), 24'($urandom()));
          random_items++;
        end
        if (queue_data(8'($urandom()))) random_items++;
      end
      wait_idle();
    end

    calm = 1'b0;
    wait_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
